@@ hw/rtl/esae_pkg.sv @@
`timescale 1ns / 1ps

package esae_pkg;

  // saturation limits on the magnitude of a 48-bit signed result
  localparam logic [47:0] SAT_POS_MAG = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SAT_NEG_MAG = 48'h8000_0000_0000;

  // reset value of the sampling period register
  localparam logic [15:0] TPS_RESET = 16'd1000;

  // request type codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_RESET  = 1'b1;

  // start request to the shared multiply-divide unit
  typedef struct packed {
    logic start;
    logic frac;   // scale the product by 2^FRAC_BITS
    logic neg;    // result is negative
  } unit_req_t;

  // unit completion status and signed, saturated result
  typedef struct packed {
    logic        done;
    logic [47:0] value;
  } unit_rsp_t;

endpackage

@@ hw/rtl/esae_in_if.sv @@
`timescale 1ns / 1ps

interface esae_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] position;
  logic        [31:0] timestamp;

  modport source (output valid, output req_type, output position, output timestamp,
                  input ready);
  modport sink   (input valid, input req_type, input position, input timestamp,
                  output ready);
endinterface

@@ hw/rtl/esae_out_if.sv @@
`timescale 1ns / 1ps

interface esae_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cur_position;
  logic signed [47:0] speed;
  logic signed [47:0] acceleration;
  logic        [31:0] sample_time;
  logic               zero_interval;

  modport source (output valid, output cur_position, output speed, output acceleration,
                  output sample_time, output zero_interval, input ready);
  modport sink   (input valid, input cur_position, input speed, input acceleration,
                  input sample_time, input zero_interval, output ready);
endinterface

@@ hw/rtl/esae_cfg_if.sv @@
`timescale 1ns / 1ps

interface esae_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/esae_divsat.sv @@
`timescale 1ns / 1ps

// shared unit: value = sign * min(floor(mag * tps * 2^(frac ? FRAC_BITS : 0) / dt), limit)
// a multiply step, then a restoring divider retiring one quotient bit per cycle
module esae_divsat #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  esae_pkg::unit_req_t req_i,
  input  logic [47:0]         mag_i,
  input  logic [15:0]         tps_i,
  input  logic [31:0]         dt_i,
  output esae_pkg::unit_rsp_t rsp_o
);

  // speed numerator stays below 2^(48+FRAC_BITS), acceleration below 2^64
  localparam int NUM_W = (48 + FRAC_BITS > 64) ? 48 + FRAC_BITS : 64;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [47:0]      mag_q, mag_d;
  logic             frac_q, frac_d;
  logic             neg_q, neg_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [31:0]      rem_q, rem_d;
  logic [47:0]      quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [63:0] prod;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;
  logic [47:0] limit;
  logic [47:0] sat_mag;

  // product of the magnitude and the sampling period
  assign prod = mag_q * tps_i;

  // one restoring division step
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dt_i};
  assign ge      = (rem_sh >= {1'b0, dt_i});

  // saturate and apply the sign
  assign limit   = neg_q ? esae_pkg::SAT_NEG_MAG : esae_pkg::SAT_POS_MAG;
  assign sat_mag = (ovf_q || (quo_q > limit)) ? limit : quo_q;

  assign rsp_o.done  = (state_q == U_FIN);
  assign rsp_o.value = neg_q ? 48'(-sat_mag) : sat_mag;

  // sequencer
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    frac_d  = frac_q;
    neg_d   = neg_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          mag_d   = mag_i;
          frac_d  = req_i.frac;
          neg_d   = req_i.neg;
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        num_d   = frac_q ? (NUM_W'(prod) << FRAC_BITS) : NUM_W'(prod);
        rem_d   = '0;
        quo_d   = '0;
        ovf_d   = 1'b0;
        cnt_d   = CNT_W'(NUM_W);
        state_d = U_DIV;
      end
      U_DIV: begin
        rem_d = ge ? rem_sub[31:0] : rem_sh[31:0];
        num_d = num_q << 1;
        quo_d = {quo_q[46:0], ge};
        ovf_d = ovf_q | quo_q[47];
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = U_FIN;
        end
      end
      U_FIN: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    frac_q <= frac_d;
    neg_q  <= neg_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    cnt_q  <= cnt_d;
  end

endmodule

@@ hw/rtl/encoder_speed_accel_estimator.sv @@
`timescale 1ns / 1ps
// order: a reset item or a zero interval item is recorded from idle, then S_DONE loads the
// output register once it is free; an update item runs S_SPD, S_ACC_GO and S_ACC, using the
// shared multiply and one-bit-per-cycle divider for each pass, then S_DONE; a new item is taken
// only in idle, and a finished result waits in the output register while the next item is taken
// reset: asynchronous active low; clears state to zero and the sampling period to 1000
module encoder_speed_accel_estimator #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  esae_in_if.sink          in_ch,
  esae_out_if.source       out_ch,
  esae_cfg_if.sink         cfg_ch
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SPD    = 3'd1;
  localparam logic [2:0] S_ACC_GO = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [15:0] tps_q;

  // architectural state
  logic [31:0] prev_pos_q, prev_pos_d;
  logic [47:0] prev_spd_q, prev_spd_d;
  logic [47:0] prev_acc_q, prev_acc_d;
  logic [31:0] prev_time_q, prev_time_d;
  logic        flag_q, flag_d;

  // per-item working registers
  logic [31:0] pos_w_q, pos_w_d;
  logic [31:0] ts_w_q, ts_w_d;
  logic [31:0] dt_q, dt_d;
  logic [47:0] spd_w_q, spd_w_d;

  // output register
  logic        out_valid_q;
  logic [31:0] out_pos_q;
  logic [47:0] out_spd_q;
  logic [47:0] out_acc_q;
  logic [31:0] out_time_q;
  logic        out_flag_q;

  logic        in_acc;
  logic        out_load;
  logic [31:0] dt_in;
  logic [32:0] pos_diff;
  logic [32:0] pos_abs;
  logic [48:0] spd_diff;
  logic [48:0] spd_abs;

  esae_pkg::unit_req_t unit_req;
  esae_pkg::unit_rsp_t unit_rsp;
  logic [47:0]         unit_mag;

  // handshakes
  assign in_ch.ready  = (state_q == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

  // elapsed ticks and position change of the incoming transaction
  assign dt_in    = in_ch.timestamp - prev_time_q;
  assign pos_diff = {in_ch.position[31], in_ch.position} - {prev_pos_q[31], prev_pos_q};
  assign pos_abs  = pos_diff[32] ? 33'(-pos_diff) : pos_diff;

  // speed change for the acceleration pass
  assign spd_diff = {spd_w_q[47], spd_w_q} - {prev_spd_q[47], prev_spd_q};
  assign spd_abs  = spd_diff[48] ? 49'(-spd_diff) : spd_diff;

  // unit requests: speed pass from idle, acceleration pass afterwards
  always_comb begin
    unit_req.start = 1'b0;
    unit_req.frac  = 1'b0;
    unit_req.neg   = 1'b0;
    unit_mag       = '0;
    if (state_q == S_IDLE) begin
      unit_req.start = in_acc && (in_ch.req_type == esae_pkg::REQ_UPDATE) && (dt_in != '0);
      unit_req.frac  = 1'b1;
      unit_req.neg   = pos_diff[32];
      unit_mag       = 48'(pos_abs);
    end else if (state_q == S_ACC_GO) begin
      unit_req.start = 1'b1;
      unit_req.neg   = spd_diff[48];
      unit_mag       = spd_abs[47:0];
    end
  end

  esae_divsat #(
    .FRAC_BITS(FRAC_BITS)
  ) u_divsat (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (unit_req),
    .mag_i (unit_mag),
    .tps_i (tps_q),
    .dt_i  (dt_q),
    .rsp_o (unit_rsp)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    prev_pos_d  = prev_pos_q;
    prev_spd_d  = prev_spd_q;
    prev_acc_d  = prev_acc_q;
    prev_time_d = prev_time_q;
    flag_d      = flag_q;
    pos_w_d     = pos_w_q;
    ts_w_d      = ts_w_q;
    dt_d        = dt_q;
    spd_w_d     = spd_w_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == esae_pkg::REQ_RESET) begin
            prev_pos_d  = in_ch.position;
            prev_spd_d  = '0;
            prev_acc_d  = '0;
            prev_time_d = in_ch.timestamp;
            flag_d      = 1'b0;
            state_d     = S_DONE;
          end else if (dt_in == '0) begin
            prev_pos_d = in_ch.position;
            flag_d     = 1'b1;
            state_d    = S_DONE;
          end else begin
            pos_w_d = in_ch.position;
            ts_w_d  = in_ch.timestamp;
            dt_d    = dt_in;
            state_d = S_SPD;
          end
        end
      end
      S_SPD: begin
        if (unit_rsp.done) begin
          spd_w_d = unit_rsp.value;
          state_d = S_ACC_GO;
        end
      end
      S_ACC_GO: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (unit_rsp.done) begin
          prev_pos_d  = pos_w_q;
          prev_spd_d  = spd_w_q;
          prev_acc_d  = unit_rsp.value;
          prev_time_d = ts_w_q;
          flag_d      = 1'b0;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tps_q       <= esae_pkg::TPS_RESET;
      prev_pos_q  <= '0;
      prev_spd_q  <= '0;
      prev_acc_q  <= '0;
      prev_time_q <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_pos_q  <= prev_pos_d;
      prev_spd_q  <= prev_spd_d;
      prev_acc_q  <= prev_acc_d;
      prev_time_q <= prev_time_d;
      flag_q      <= flag_d;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tps_q <= cfg_ch.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    pos_w_q <= pos_w_d;
    ts_w_q  <= ts_w_d;
    dt_q    <= dt_d;
    spd_w_q <= spd_w_d;
    if (out_load) begin
      out_pos_q  <= prev_pos_q;
      out_spd_q  <= prev_spd_q;
      out_acc_q  <= prev_acc_q;
      out_time_q <= prev_time_q;
      out_flag_q <= flag_q;
    end
  end

  // result channel
  assign out_ch.valid         = out_valid_q;
  assign out_ch.cur_position  = out_pos_q;
  assign out_ch.speed         = out_spd_q;
  assign out_ch.acceleration  = out_acc_q;
  assign out_ch.sample_time   = out_time_q;
  assign out_ch.zero_interval = out_flag_q;

endmodule

@@ hw/rtl/esae_checker.sv @@
`timescale 1ns / 1ps

module esae_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_pos_i,
  input logic [47:0] out_spd_i,
  input logic [47:0] out_acc_i
);

  // a result waiting on a stalled sink stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pos_i) && $stable(out_spd_i)
      && $stable(out_acc_i))
    else $error("stalled result changed");

  // the block is busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // a new result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in flight");

endmodule

bind encoder_speed_accel_estimator esae_checker u_esae_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_ch.valid),
  .in_ready_i (in_ch.ready),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .out_pos_i  (out_ch.cur_position),
  .out_spd_i  (out_ch.speed),
  .out_acc_i  (out_ch.acceleration)
);

@@ sim/encoder_speed_accel_estimator_test.sv @@
`timescale 1ns / 1ps

module encoder_speed_accel_estimator_test;

  localparam int FRAC_BITS = 16;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_ITEMS = 104;
  localparam int NUM_PHASES = 8;

  // one encoder reading as offered to the block
  typedef struct packed {
    logic        req_type;
    logic [31:0] position;
    logic [31:0] timestamp;
  } reading_t;

  // one position, speed and acceleration estimate
  typedef struct packed {
    logic [31:0] cur_position;
    logic [47:0] speed;
    logic [47:0] acceleration;
    logic [31:0] sample_time;
    logic        zero_interval;
  } estimate_t;

  logic clk_i;
  logic rst_ni;

  esae_in_if  in_ch ();
  esae_out_if out_ch ();
  esae_cfg_if cfg_ch ();

  encoder_speed_accel_estimator #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // estimator state mirrored by the testbench
  logic [15:0]        period;
  logic signed [31:0] est_pos;
  logic signed [47:0] est_speed;
  logic signed [47:0] est_accel;
  logic [31:0]        est_time;

  reading_t  pending_q[$];
  estimate_t estimates_q[$];

  // trajectory of the reading generator
  logic [31:0] gen_pos;
  logic [31:0] gen_ts;

  logic idle_on;
  int   hold_asked;
  int   hold_taken;
  int   hold_left;
  int   stall_left;
  int   gap_left;
  int   quiet;
  int   errors;
  int   sent;
  int   resets_sent;
  int   checked;
  int   zero_seen;
  int   periods_set;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length: none while idle_on is off; otherwise mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // trunc(diff * period * 2^shift / dt), saturated to the 48-bit signed range
  function automatic logic [47:0] scaled_rate(logic signed [63:0] diff, int unsigned shift,
                                              logic [31:0] dt);
    logic [63:0] mag;
    logic [95:0] quo;
    logic [47:0] lim;
    mag = diff[63] ? 64'(-diff) : 64'(diff);
    lim = diff[63] ? esae_pkg::SAT_NEG_MAG : esae_pkg::SAT_POS_MAG;
    quo = ((96'(mag) * 96'(period)) << shift) / 96'(dt);
    if (quo > 96'(lim)) quo = 96'(lim);
    return diff[63] ? -quo[47:0] : quo[47:0];
  endfunction

  // advance the mirrored state by one reading and form the estimate
  function automatic estimate_t estimate(reading_t rd);
    estimate_t          res;
    logic [31:0]        dt;
    logic signed [63:0] dpos;
    logic signed [63:0] dspd;
    logic signed [47:0] spd;
    res.zero_interval = 1'b0;
    dt = rd.timestamp - est_time;
    if (rd.req_type == esae_pkg::REQ_RESET) begin
      est_pos   = rd.position;
      est_speed = '0;
      est_accel = '0;
      est_time  = rd.timestamp;
    end else if (dt == 32'd0) begin
      res.zero_interval = 1'b1;
      est_pos = rd.position;
    end else begin
      dpos = signed'(rd.position);
      dpos = dpos - est_pos;
      spd  = scaled_rate(dpos, FRAC_BITS, dt);
      dspd = spd;
      dspd = dspd - est_speed;
      est_accel = scaled_rate(dspd, 0, dt);
      est_speed = spd;
      est_pos   = rd.position;
      est_time  = rd.timestamp;
    end
    res.cur_position = est_pos;
    res.speed        = est_speed;
    res.acceleration = est_accel;
    res.sample_time  = est_time;
    return res;
  endfunction

  // smooth motion mostly, with resets, repeated timestamps, jumps and noise
  function automatic reading_t random_reading();
    reading_t    rd;
    int unsigned r;
    r = $urandom_range(99);
    rd.req_type = esae_pkg::REQ_UPDATE;
    if (r < 8) begin
      rd.req_type  = esae_pkg::REQ_RESET;
      rd.position  = $urandom;
      rd.timestamp = $urandom;
    end else if (r < 16) begin
      rd.req_type  = 1'($urandom_range(1));
      rd.position  = $urandom;
      rd.timestamp = $urandom;
    end else begin
      if ($urandom_range(99) < 10) rd.position = gen_pos + $urandom;
      else rd.position = gen_pos + 32'($urandom_range(4000)) - 32'd2000;
      if (r < 22) rd.timestamp = gen_ts;
      else if (r < 30) rd.timestamp = gen_ts + $urandom;
      else if (r < 45) rd.timestamp = gen_ts + 32'($urandom_range(1, 20));
      else rd.timestamp = gen_ts + 32'($urandom_range(1, 3000));
    end
    gen_pos = rd.position;
    gen_ts  = rd.timestamp;
    return rd;
  endfunction

  task automatic send(logic rt, logic [31:0] pos, logic [31:0] ts);
    reading_t rd;
    rd.req_type  = rt;
    rd.position  = pos;
    rd.timestamp = ts;
    pending_q.push_back(rd);
    gen_pos = pos;
    gen_ts  = ts;
  endtask

  // wait until every reading is taken and every estimate has come back
  task automatic settle();
    while (pending_q.size() != 0 || in_ch.valid || estimates_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_period(logic [15:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    period = value;
    periods_set++;
  endtask

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // reading driver: predicts each accepted transaction, then offers the next
  always @(posedge clk_i) begin : drive_readings
    reading_t rd;
    logic     offer;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        rd.req_type  = in_ch.req_type;
        rd.position  = in_ch.position;
        rd.timestamp = in_ch.timestamp;
        estimates_q.push_back(estimate(rd));
        sent++;
        if (rd.req_type == esae_pkg::REQ_RESET) resets_sent++;
        gap_left = pick_gap();
      end
      offer = in_ch.valid && !in_ch.ready;
      if (!offer && gap_left > 0) begin
        gap_left--;
      end else if (!offer && pending_q.size() != 0) begin
        rd = pending_q.pop_front();
        in_ch.req_type  <= rd.req_type;
        in_ch.position  <= rd.position;
        in_ch.timestamp <= rd.timestamp;
        offer = 1'b1;
      end
      in_ch.valid <= offer;
    end
  end

  // receiver ready: random stalls plus the requested long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_taken + 1;
      hold_left  <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(99) < 20) begin
      stall_left <= pick_gap();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor: compare each transaction with the oldest estimate
  always @(posedge clk_i) begin : watch_estimates
    estimate_t want;
    estimate_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.cur_position  = out_ch.cur_position;
      got.speed         = out_ch.speed;
      got.acceleration  = out_ch.acceleration;
      got.sample_time   = out_ch.sample_time;
      got.zero_interval = out_ch.zero_interval;
      if (estimates_q.size() == 0) begin
        $error("estimate with no reading outstanding: position %0h", got.cur_position);
        errors++;
      end else begin
        want = estimates_q.pop_front();
        check_field("cur_position", 48'(want.cur_position), 48'(got.cur_position));
        check_field("speed", want.speed, got.speed);
        check_field("acceleration", want.acceleration, got.acceleration);
        check_field("sample_time", 48'(want.sample_time), 48'(got.sample_time));
        check_field("zero_interval", 48'(want.zero_interval), 48'(got.zero_interval));
        checked++;
        if (want.zero_interval) zero_seen++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = esae_pkg::REQ_UPDATE;
    in_ch.position = '0;
    in_ch.timestamp = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    period = esae_pkg::TPS_RESET;
    est_pos = '0;
    est_speed = '0;
    est_accel = '0;
    est_time = '0;
    gen_pos = '0;
    gen_ts = '0;
    idle_on = 1'b1;
    hold_asked = 0;
    hold_taken = 0;
    hold_left = 0;
    stall_left = 0;
    gap_left = 0;
    quiet = 0;
    errors = 0;
    sent = 0;
    resets_sent = 0;
    checked = 0;
    zero_seen = 0;
    periods_set = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset period: zero interval from reset, wraps, saturation, truncation
    send(esae_pkg::REQ_UPDATE, 32'd0, 32'd0);
    send(esae_pkg::REQ_UPDATE, 32'd100, 32'd1000);
    send(esae_pkg::REQ_UPDATE, 32'd300, 32'd1500);
    send(esae_pkg::REQ_UPDATE, 32'd400, 32'd1500);
    send(esae_pkg::REQ_RESET, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
    send(esae_pkg::REQ_UPDATE, 32'h8000_0000, 32'h0000_0010);
    send(esae_pkg::REQ_UPDATE, 32'h7FFF_FFFF, 32'h0000_0011);
    send(esae_pkg::REQ_RESET, 32'h8000_0000, 32'd0);
    send(esae_pkg::REQ_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
    send(esae_pkg::REQ_RESET, 32'd0, 32'hFFFF_FFFF);
    send(esae_pkg::REQ_UPDATE, 32'hFFFF_FFFB, 32'd2);
    send(esae_pkg::REQ_UPDATE, 32'hFFFF_FFFB, 32'd5);
    send(esae_pkg::REQ_UPDATE, 32'd1, 32'h8000_0000);
    settle();

    // longest period: speed saturates upward, acceleration saturates each way
    write_period(16'hFFFF);
    send(esae_pkg::REQ_RESET, 32'h8000_0000, 32'd0);
    send(esae_pkg::REQ_UPDATE, 32'h7FFF_FFFF, 32'd1);
    send(esae_pkg::REQ_UPDATE, 32'h7FFF_FFFF, 32'd2);
    send(esae_pkg::REQ_UPDATE, 32'h8000_0000, 32'd2);
    send(esae_pkg::REQ_UPDATE, 32'd0, 32'hFFFF_FFFF);
    settle();

    // zero period: speed forced to zero
    write_period(16'd0);
    send(esae_pkg::REQ_UPDATE, 32'd12345, 32'd100);
    send(esae_pkg::REQ_UPDATE, 32'hFFFF_FFF9, 32'd200);
    settle();

    // unit period with wrap and negative truncation
    write_period(16'd1);
    send(esae_pkg::REQ_RESET, 32'd0, 32'hFFFF_FFFE);
    send(esae_pkg::REQ_UPDATE, 32'd3, 32'd1);
    send(esae_pkg::REQ_UPDATE, 32'hFFFF_FFFC, 32'd4);
    settle();

    // random phases over a range of periods
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_period(esae_pkg::TPS_RESET);
        2: write_period(16'hFFFF);
        3: write_period(16'd1);
        4: write_period(16'($urandom_range(1, 100)));
        5: write_period(16'd0);
        default: write_period(16'($urandom_range(1, 65535)));
      endcase
      idle_on = (ph != 4);
      if (ph == 2) hold_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) pending_q.push_back(random_reading());
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (estimates_q.size() != 0) begin
      $error("%0d estimates never arrived", estimates_q.size());
      errors++;
    end
    $display("covered %0d readings (%0d resets) under %0d sampling period settings",
             sent, resets_sent, periods_set);
    $display("compared %0d estimates, %0d of them with a zero interval", checked, zero_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
